FILE: sv/rbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbb_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  // Fixed field widths
  localparam int WINDOW_BITS = 7;
  localparam int MULT_BITS   = 12;
  localparam int FRAC_BITS   = 8;
  localparam int MIDDLE_BITS = 32;
  localparam int BAND_BITS   = 36;

  // Configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_MULTIPLIER = 8'd1;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd20;
  localparam logic [MULT_BITS-1:0]   MULT_RESET   = 12'd512;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic rd_en;
    logic mul_load_pq;
    logic mul_load_ss;
    logic mul_step;
    logic mul_sub;
    logic mean_load;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic spread_load;
    logic bands_load;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enough;
    logic rd_last;
    logic pipe_busy;
    logic mul_done;
    logic iter_last;
    logic mean_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: sv/rbb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/rbb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rbb_ctrl
  import rbb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    price_valid,
  output logic         price_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_ACCUM  = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_MUL_PQ = 4'd4;
  localparam logic [3:0] S_MUL_SS = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_SPREAD = 4'd8;
  localparam logic [3:0] S_BANDS  = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign price_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (price_valid) begin
          cmd.start  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = st.enough ? S_ACCUM : S_FINISH;
      end
      S_ACCUM: begin
        cmd.rd_en = 1'b1;
        if (st.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last squares to land in the accumulators
        if (!st.pipe_busy) begin
          cmd.mul_load_pq = 1'b1;
          cmd.mean_load   = 1'b1;
          state_next      = S_MUL_PQ;
        end
      end
      S_MUL_PQ: begin
        if (st.mul_done) begin
          cmd.mul_load_ss = 1'b1;
          state_next      = S_MUL_SS;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_MUL_SS: begin
        if (st.mul_done) begin
          cmd.div_load = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.mul_step = 1'b1;
          cmd.mul_sub  = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.iter_last) begin
          cmd.sqrt_load = 1'b1;
          state_next    = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (st.iter_last) begin
          state_next = S_SPREAD;
        end
      end
      S_SPREAD: begin
        cmd.spread_load = 1'b1;
        state_next      = S_BANDS;
      end
      S_BANDS: begin
        if (!st.mean_busy) begin
          cmd.bands_load = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/rbb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rbb_datapath
  import rbb_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cmd_t                        cmd,
  output status_t                          st,
  input  wire logic [PRICE_BITS-1:0]       close_price,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                        result_ready,
  output logic                             result_valid,
  output logic                             bands_valid,
  output logic [MIDDLE_BITS-1:0]           middle_band,
  output logic [BAND_BITS-1:0]             upper_band,
  output logic signed [BAND_BITS-1:0]      lower_band
);

  localparam int PB  = PRICE_BITS;
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = PB + CW;
  localparam int QW  = 2 * PB + CW;
  localparam int NW  = 2 * PB + 2 * CW;
  localparam int DW  = 2 * CW;
  localparam int IW  = $clog2(NW + 1);
  localparam int MW  = $clog2(SW + 1);
  localparam int HB  = (PB + 1) / 2;
  localparam int HW  = PB - HB;
  localparam int SPW = PB + MULT_BITS - FRAC_BITS;
  localparam int EW  = (PB + 6 > BAND_BITS + 2) ? PB + 6 : BAND_BITS + 2;

  localparam logic [EW-1:0] UPPER_MAX = (EW'(1) << BAND_BITS) - EW'(1);
  localparam logic signed [EW-1:0] LOWER_MIN = -(EW'(1) << (BAND_BITS - 1));

  // Configuration
  logic [WINDOW_BITS-1:0] window_length;
  logic [MULT_BITS-1:0]   width_multiplier;
  logic [CW-1:0]          period;

  // Ring and counters
  logic [AW-1:0] write_slot;
  logic [CW-1:0] samples_seen;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] rd_cnt;
  logic [PB-1:0] rdata;
  logic          rd_valid;

  // Square pipeline and accumulators
  logic          pp_valid;
  logic [PB-1:0] pp_x;
  logic [2*HW-1:0] pp_hh;
  logic [PB-1:0]   pp_hl;
  logic [2*HB-1:0] pp_ll;
  logic [HW-1:0]   x_hi;
  logic [HB-1:0]   x_lo;
  logic [QW-1:0]   sq;
  logic [SW-1:0]   sum;
  logic [QW-1:0]   sumsq;

  // Shared shift register: numerator, then quotient, then sqrt operand
  logic [NW-1:0] num;
  logic [NW-1:0] mcand;
  logic [SW-1:0] mplier;
  logic [IW-1:0] iter_cnt;

  // Divide by period squared
  logic [DW-1:0] dvsr;
  logic [DW-1:0] drem;
  logic [DW:0]   d_shift;
  logic [DW:0]   d_diff;
  logic          d_ge;

  // Square root
  logic [PB-1:0]   root;
  logic [PB+1:0]   srem;
  logic [PB+3:0]   s_shift;
  logic [PB+3:0]   s_trial;
  logic [PB+3:0]   s_diff;
  logic            s_ge;

  // Mean divider
  logic [SW-1:0] mq;
  logic [CW-1:0] mrem;
  logic [MW-1:0] mcnt;
  logic [CW:0]   m_shift;
  logic [CW:0]   m_diff;
  logic          m_ge;

  // Bands
  logic [SPW-1:0]         spread;
  logic [EW-1:0]          upper_w;
  logic signed [EW-1:0]   lower_w;
  logic [MIDDLE_BITS-1:0] held_middle;
  logic [BAND_BITS-1:0]   held_upper;
  logic signed [BAND_BITS-1:0] held_lower;
  logic                   fresh;

  always_comb begin
    if (window_length == '0) begin
      period = CW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      period = CW'(MAX_WINDOW);
    end else begin
      period = CW'(window_length);
    end
  end

  rbb_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.start),
    .waddr (write_slot),
    .wdata (close_price),
    .re    (cmd.rd_en),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  assign x_hi = rdata[PB-1:HB];
  assign x_lo = rdata[HB-1:0];
  assign sq   = QW'({pp_hh, pp_ll}) + (QW'(pp_hl) << (HB + 1));

  assign d_shift = {drem, num[NW-1]};
  assign d_diff  = d_shift - (DW + 1)'(dvsr);
  assign d_ge    = (d_shift >= (DW + 1)'(dvsr));

  assign s_shift = {srem, num[2*PB-1 -: 2]};
  assign s_trial = (PB + 4)'({root, 2'b01});
  assign s_diff  = s_shift - s_trial;
  assign s_ge    = (s_shift >= s_trial);

  assign m_shift = {mrem, mq[SW-1]};
  assign m_diff  = m_shift - (CW + 1)'(period);
  assign m_ge    = (m_shift >= (CW + 1)'(period));

  assign upper_w = EW'(mq) + EW'(spread);
  assign lower_w = $signed(EW'(mq)) - $signed(EW'(spread));

  assign st.enough    = (samples_seen >= period);
  assign st.rd_last   = (rd_cnt == CW'(1));
  assign st.pipe_busy = rd_valid | pp_valid;
  assign st.mul_done  = (mplier == '0);
  assign st.iter_last = (iter_cnt == IW'(1));
  assign st.mean_busy = (mcnt != '0);
  assign st.out_free  = !result_valid || result_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WINDOW_RESET;
      width_multiplier <= MULT_RESET;
      write_slot       <= '0;
      samples_seen     <= '0;
      rd_valid         <= 1'b0;
      pp_valid         <= 1'b0;
      mcnt             <= '0;
      held_middle      <= '0;
      held_upper       <= '0;
      held_lower       <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:    window_length    <= cfg_data[WINDOW_BITS-1:0];
          REG_WIDTH_MULTIPLIER: width_multiplier <= cfg_data[MULT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        write_slot <= (write_slot == AW'(MAX_WINDOW - 1)) ? '0 : write_slot + AW'(1);
        if (samples_seen != CW'(MAX_WINDOW)) begin
          samples_seen <= samples_seen + CW'(1);
        end
      end
      rd_valid <= cmd.rd_en;
      pp_valid <= rd_valid;
      if (cmd.mean_load) begin
        mcnt <= MW'(SW);
      end else if (mcnt != '0) begin
        mcnt <= mcnt - MW'(1);
      end
      if (cmd.bands_load) begin
        held_middle <= MIDDLE_BITS'(mq);
        held_upper  <= (upper_w > UPPER_MAX) ? '1 : upper_w[BAND_BITS-1:0];
        held_lower  <= (lower_w < LOWER_MIN) ? LOWER_MIN[BAND_BITS-1:0]
                                             : lower_w[BAND_BITS-1:0];
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_ptr <= write_slot;
      rd_cnt <= period;
      sum    <= '0;
      sumsq  <= '0;
      fresh  <= 1'b0;
    end else if (cmd.rd_en) begin
      // walk back from the newest price
      rd_ptr <= (rd_ptr == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr - AW'(1);
      rd_cnt <= rd_cnt - CW'(1);
    end

    if (rd_valid) begin
      pp_x  <= rdata;
      pp_hh <= (2 * HW)'(x_hi) * (2 * HW)'(x_hi);
      pp_hl <= PB'(x_hi) * PB'(x_lo);
      pp_ll <= (2 * HB)'(x_lo) * (2 * HB)'(x_lo);
    end
    if (pp_valid) begin
      sum   <= sum + SW'(pp_x);
      sumsq <= sumsq + sq;
    end

    // P*Q - S*S by shift and add
    if (cmd.mul_load_pq) begin
      num    <= '0;
      mcand  <= NW'(sumsq);
      mplier <= SW'(period);
    end else if (cmd.mul_load_ss) begin
      mcand  <= NW'(sum);
      mplier <= sum;
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        num <= cmd.mul_sub ? num - mcand : num + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end else if (cmd.div_step) begin
      num <= {num[NW-2:0], d_ge};
    end else if (cmd.sqrt_step) begin
      num <= num << 2;
    end

    if (cmd.div_load) begin
      dvsr     <= DW'(period) * DW'(period);
      drem     <= '0;
      iter_cnt <= IW'(NW);
    end else if (cmd.sqrt_load) begin
      iter_cnt <= IW'(PB);
    end else if (cmd.div_step || cmd.sqrt_step) begin
      iter_cnt <= iter_cnt - IW'(1);
    end
    if (cmd.div_step) begin
      drem <= d_ge ? d_diff[DW-1:0] : d_shift[DW-1:0];
    end

    if (cmd.sqrt_load) begin
      root <= '0;
      srem <= '0;
    end else if (cmd.sqrt_step) begin
      root <= {root[PB-2:0], s_ge};
      srem <= s_ge ? s_diff[PB+1:0] : s_shift[PB+1:0];
    end

    if (cmd.mean_load) begin
      mq   <= sum;
      mrem <= '0;
    end else if (mcnt != '0) begin
      mq   <= {mq[SW-2:0], m_ge};
      mrem <= m_ge ? m_diff[CW-1:0] : m_shift[CW-1:0];
    end

    if (cmd.spread_load) begin
      spread <= SPW'(((PB + MULT_BITS)'(root) * (PB + MULT_BITS)'(width_multiplier))
                     >> FRAC_BITS);
    end
    if (cmd.bands_load) begin
      fresh <= 1'b1;
    end

    if (cmd.out_load) begin
      bands_valid <= fresh;
      middle_band <= held_middle;
      upper_band  <= held_upper;
      lower_band  <= held_lower;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rolling_bollinger_bands_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Rolling Bollinger bands over closing prices in unsigned Q24.8.
// Channels: price (close_price, valid/ready), result (bands_valid,
// middle_band, upper_band, lower_band, valid/ready) and a config write
// channel (cfg_index, cfg_data) that is always ready. Index 0 sets the
// window length, index 1 the Q4.8 deviation multiplier.
// Each price beat yields exactly one result beat. Before the window is
// full the result carries the held bands with bands_valid low. With a
// full window of p prices the work is one ring read per price, then two
// bit-serial multiplies for the variance numerator, a one-bit-per-cycle
// divide by p squared and a two-bits-per-cycle root. One price is worked
// on at a time; price_ready rises in the same cycle as the result appears
// in the output register, so a new price is taken while that result
// still waits. A stalled receiver holds the result and the next computed
// result waits for the output register. Reset clears the sample count,
// ring pointer and held bands and restores the default configuration;
// ring contents are never cleared.
module rolling_bollinger_bands_top
  import rbb_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      price_valid,
  output logic                           price_ready,
  input  wire logic [PRICE_BITS-1:0]     close_price,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic                           bands_valid,
  output logic [MIDDLE_BITS-1:0]         middle_band,
  output logic [BAND_BITS-1:0]           upper_band,
  output logic signed [BAND_BITS-1:0]    lower_band,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  rbb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .price_valid (price_valid),
    .price_ready (price_ready),
    .st          (st),
    .cmd         (cmd)
  );

  rbb_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .close_price  (close_price),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .bands_valid  (bands_valid),
    .middle_band  (middle_band),
    .upper_band   (upper_band),
    .lower_band   (lower_band)
  );

endmodule
`default_nettype wire
